[rtl/lbp_3x3_census_stream_unit_assert.svh]
// ----------------------------------------------------------------------------
// LBP census stream assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LBP_3X3_CENSUS_STREAM_UNIT_ASSERT_SVH
`define LBP_3X3_CENSUS_STREAM_UNIT_ASSERT_SVH

// same-cycle implication
`define LBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// lbp_pkg
// Types, register map and code function for the 3x3 LBP census stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  localparam int PIX_BITS      = 8;
  localparam int IMG_W_BITS    = 12;
  localparam int COL_CFG_BITS  = 11;
  localparam int ROW_CFG_BITS  = 12;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 3;

  typedef logic [PIX_BITS-1:0] pix_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_ROI_LEFT    = 3'd1,
    CFG_ROI_TOP     = 3'd2,
    CFG_ROI_COLUMNS = 3'd3,
    CFG_ROI_ROWS    = 3'd4
  } cfg_idx_t;

  localparam logic [IMG_W_BITS-1:0]   IMAGE_WIDTH_RST = 12'd640;
  localparam logic [COL_CFG_BITS-1:0] ROI_LEFT_RST    = 11'd1;
  localparam logic [ROW_CFG_BITS-1:0] ROI_TOP_RST     = 12'd1;
  localparam logic [COL_CFG_BITS-1:0] ROI_COLUMNS_RST = 11'd638;
  localparam logic [ROW_CFG_BITS-1:0] ROI_ROWS_RST    = 12'd478;

  // neighbours in bit order: TL, T, TR, L, R, BL, B, BR
  function automatic pix_t lbp_code(input pix_t tl, input pix_t tp, input pix_t tr,
                                    input pix_t lf, input pix_t ctr, input pix_t rt,
                                    input pix_t bl, input pix_t bt, input pix_t br);
    pix_t code;
    code[0] = (tl >= ctr);
    code[1] = (tp >= ctr);
    code[2] = (tr >= ctr);
    code[3] = (lf >= ctr);
    code[4] = (rt >= ctr);
    code[5] = (bl >= ctr);
    code[6] = (bt >= ctr);
    code[7] = (br >= ctr);
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/lbp_ram.sv]
// ----------------------------------------------------------------------------
// lbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/lbp_3x3_census_stream_unit.sv]
// ----------------------------------------------------------------------------
// lbp_3x3_census_stream_unit
// 3x3 local binary pattern over a raster pixel stream with two line buffers.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      in         in_valid/in_stall   in_pixel, in_frame_start
// out_     out        out_valid/out_stall out_code, out_row_last, out_frame_last
// cfg_     in         cfg_we              cfg_index, cfg_wdata
//
// One pixel per clock sustained unless out_stall holds a pending code; a code
// passes through stage 1 to the output register (read on the accepting edge,
// compute and write-back as it advances). Same-entry read/write overlap is forwarded.
// Reset is synchronous; line buffers are not cleared, so no clearing pass.
// An out_stall holds the output register and, once stage 1 is blocked too,
// raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lbp_3x3_census_stream_unit_assert.svh"

module lbp_3x3_census_stream_unit
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [PIX_BITS-1:0]      in_pixel,
  input  wire logic                     in_frame_start,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic      [PIX_BITS-1:0]      out_code,
  output logic                          out_row_last,
  output logic                          out_frame_last,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int MAXCR = (CW > RW) ? CW : RW;
  localparam int CMPW  = ((MAXCR > IMG_W_BITS) ? MAXCR : IMG_W_BITS) + 2;

  // configuration
  logic [IMG_W_BITS-1:0]   image_width_r;
  logic [COL_CFG_BITS-1:0] roi_left_r;
  logic [ROW_CFG_BITS-1:0] roi_top_r;
  logic [COL_CFG_BITS-1:0] roi_columns_r;
  logic [ROW_CFG_BITS-1:0] roi_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      roi_left_r    <= ROI_LEFT_RST;
      roi_top_r     <= ROI_TOP_RST;
      roi_columns_r <= ROI_COLUMNS_RST;
      roi_rows_r    <= ROI_ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: image_width_r <= cfg_wdata[IMG_W_BITS-1:0];
        CFG_ROI_LEFT:    roi_left_r    <= cfg_wdata[COL_CFG_BITS-1:0];
        CFG_ROI_TOP:     roi_top_r     <= cfg_wdata[ROW_CFG_BITS-1:0];
        CFG_ROI_COLUMNS: roi_columns_r <= cfg_wdata[COL_CFG_BITS-1:0];
        CFG_ROI_ROWS:    roi_rows_r    <= cfg_wdata[ROW_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic          in_accept;
  logic          s1_adv;
  logic          s1_valid_r;
  logic          s1_emit_r, s1_rl_r, s1_fl_r;
  logic [CW-1:0] s1_idx_r;
  pix_t          s1_px_r;
  logic          s1_fwd_r;
  pix_t          s1_fwd_t_r, s1_fwd_m_r;
  logic          out_valid_r;
  pix_t          out_code_r;
  logic          out_row_last_r, out_frame_last_r;

  assign s1_adv    = s1_valid_r && (!s1_emit_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // stage 0: position, ROI test, line-buffer read
  logic [CW-1:0]   col_r, col_nxt, c_cur;
  logic [RW-1:0]   row_r, row_nxt, r_cur;
  logic [CMPW-1:0] width_eff, c_ext, r_ext, cx, cy, col_end, row_end;
  logic            wrap, emit_s0, rl_s0, fl_s0;

  always_comb begin
    if (CMPW'(image_width_r) > CMPW'(MAX_WIDTH)) begin
      width_eff = CMPW'(MAX_WIDTH);
    end else if (image_width_r == '0) begin
      width_eff = CMPW'(1);
    end else begin
      width_eff = CMPW'(image_width_r);
    end
    c_cur   = in_frame_start ? '0 : col_r;
    r_cur   = in_frame_start ? '0 : row_r;
    c_ext   = CMPW'(c_cur);
    r_ext   = CMPW'(r_cur);
    cx      = c_ext - CMPW'(1);
    cy      = r_ext - CMPW'(1);
    col_end = CMPW'(roi_left_r) + CMPW'(roi_columns_r);
    row_end = CMPW'(roi_top_r) + CMPW'(roi_rows_r);
    emit_s0 = (c_ext >= CMPW'(2)) && (r_ext >= CMPW'(2)) &&
              (cx >= CMPW'(roi_left_r)) && (cx < col_end) &&
              (cy >= CMPW'(roi_top_r)) && (cy < row_end);
    rl_s0   = (cx == col_end - CMPW'(1));
    fl_s0   = rl_s0 && (cy == row_end - CMPW'(1));
    wrap    = (c_ext + CMPW'(1)) >= width_eff;
    col_nxt = wrap ? '0 : c_cur + CW'(1);
    row_nxt = (wrap && (r_cur < RW'(MAX_HEIGHT - 1))) ? r_cur + RW'(1) : r_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line buffers
  pix_t ram_t_rd, ram_m_rd, t_sel, m_sel;

  assign t_sel = s1_fwd_r ? s1_fwd_t_r : ram_t_rd;
  assign m_sel = s1_fwd_r ? s1_fwd_m_r : ram_m_rd;

  lbp_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (m_sel),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (ram_t_rd)
  );

  lbp_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (s1_px_r),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (ram_m_rd)
  );

  // stage 1 registers; forward the write-back that lands on the entry just read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r    <= in_pixel;
      s1_idx_r   <= c_cur;
      s1_emit_r  <= emit_s0;
      s1_rl_r    <= rl_s0;
      s1_fl_r    <= fl_s0;
      s1_fwd_r   <= s1_adv && (s1_idx_r == c_cur);
      s1_fwd_t_r <= m_sel;
      s1_fwd_m_r <= s1_px_r;
    end
  end

  // window: entries 0..2 column c-2, 3..5 column c-1, top to bottom
  pix_t win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= t_sel;
      win_r[4] <= m_sel;
      win_r[5] <= s1_px_r;
    end
  end

  pix_t code_s1;

  assign code_s1 = lbp_code(win_r[0], win_r[3], t_sel,
                            win_r[1], win_r[4], m_sel,
                            win_r[2], win_r[5], s1_px_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_code_r       <= code_s1;
      out_row_last_r   <= s1_rl_r;
      out_frame_last_r <= s1_fl_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign out_row_last   = out_row_last_r;
  assign out_frame_last = out_frame_last_r;

  `LBP_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv,
                   s1_valid_r && $stable(s1_px_r) && $stable(s1_idx_r),
                   "stage 1 item lost while blocked")
  `LBP_ASSERT_NEXT(a_fwd_set, in_accept && s1_adv && (s1_idx_r == c_cur),
                   s1_fwd_r, "same-entry write-back not forwarded")
  `LBP_ASSERT_NEXT(a_emit_out, s1_adv && s1_emit_r, out_valid_r,
                   "emitted code not in output register")
  `LBP_ASSERT_NOW(a_last_flags, out_valid_r && out_frame_last_r, out_row_last_r,
                  "frame_last without row_last")

endmodule

`default_nettype wire

[tb/lbp_3x3_census_stream_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_3x3_census_stream_unit_tb
// Streams raster frames through the LBP census unit. A local line-buffer
// predictor works out each code as its pixel is taken, and the output side
// checks every code against that store. Both handshakes idle at random.
// ----------------------------------------------------------------------------

module lbp_3x3_census_stream_unit_tb
  import lbp_pkg::*;
();

  localparam int LB_DEPTH     = 2048;
  localparam int ROW_SAT      = 4095;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TIMEOUT_NS   = 50_000_000;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } pixel_item_t;

  typedef struct packed {
    pix_t code;
    logic row_last;
    logic frame_last;
  } lbp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [PIX_BITS-1:0]      in_pixel = '0;
  logic                     in_frame_start = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PIX_BITS-1:0]      out_code;
  logic                     out_row_last;
  logic                     out_frame_last;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  lbp_3x3_census_stream_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code       (out_code),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // predictor state
  pix_t        row1_buf [LB_DEPTH];
  pix_t        row2_buf [LB_DEPTH];
  pix_t        win [6];
  logic [10:0] col_cnt;
  logic [11:0] row_cnt;
  logic [11:0] cfg_width;
  logic [10:0] cfg_left;
  logic [11:0] cfg_top;
  logic [10:0] cfg_cols;
  logic [11:0] cfg_rows;

  pixel_item_t pixel_queue [$];
  lbp_result_t pending_codes [$];

  int  pixels_sent   = 0;
  int  pixels_taken  = 0;
  int  codes_seen    = 0;
  int  mismatch_count = 0;
  int  reg_writes    = 0;
  int  phases        = 0;
  int  gap_left      = 0;
  int  stall_left    = 0;
  bit  send_idle_on  = 1'b0;
  bit  stall_on      = 1'b0;

  function automatic int draw_wait(input bit on);
    if (!on || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic pix_t draw_pixel(input int mode);
    case (mode)
      0:       return pix_t'($urandom_range(0, 255));
      1:       return pix_t'($urandom_range(0, 3));
      2:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return pix_t'($urandom_range(126, 130));
    endcase
  endfunction

  function automatic void clear_census_state();
    for (int i = 0; i < LB_DEPTH; i++) begin
      row1_buf[i] = '0;
      row2_buf[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_cnt   = '0;
    row_cnt   = '0;
    cfg_width = IMAGE_WIDTH_RST;
    cfg_left  = ROI_LEFT_RST;
    cfg_top   = ROI_TOP_RST;
    cfg_cols  = ROI_COLUMNS_RST;
    cfg_rows  = ROI_ROWS_RST;
  endfunction

  // One taken pixel: may complete the window of the centre above-left of it.
  function automatic void compute_census(input pix_t px, input logic fs);
    int unsigned w, c, r, cx, cy, col_end, row_end, idx;
    pix_t t, m, ctr;
    lbp_result_t res;
    w = 32'(cfg_width);
    if (w > LB_DEPTH) w = LB_DEPTH;
    if (w == 0) w = 1;
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    c   = 32'(col_cnt);
    r   = 32'(row_cnt);
    idx = c % LB_DEPTH;
    t   = row2_buf[idx];
    m   = row1_buf[idx];
    if (c >= 2 && r >= 2) begin
      cx      = c - 1;
      cy      = r - 1;
      col_end = 32'(cfg_left) + 32'(cfg_cols);
      row_end = 32'(cfg_top) + 32'(cfg_rows);
      if (cx >= 32'(cfg_left) && cx < col_end && cy >= 32'(cfg_top) && cy < row_end) begin
        ctr = win[4];
        res.code[0] = (win[0] >= ctr);
        res.code[1] = (win[3] >= ctr);
        res.code[2] = (t >= ctr);
        res.code[3] = (win[1] >= ctr);
        res.code[4] = (m >= ctr);
        res.code[5] = (win[2] >= ctr);
        res.code[6] = (win[5] >= ctr);
        res.code[7] = (px >= ctr);
        res.row_last   = (cx == col_end - 1);
        res.frame_last = res.row_last && (cy == row_end - 1);
        pending_codes.push_back(res);
      end
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = t;
    win[4] = m;
    win[5] = px;
    row2_buf[idx] = m;
    row1_buf[idx] = px;
    if (c + 1 >= w) begin
      col_cnt = '0;
      if (row_cnt < ROW_SAT) row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = 11'(c + 1);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    pixel_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        compute_census(in_pixel, in_frame_start);
        pixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          it = pixel_queue.pop_front();
          in_valid       <= 1'b1;
          in_pixel       <= it.pixel;
          in_frame_start <= it.frame_start;
          pixels_sent++;
          gap_left = draw_wait(send_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lbp_result_t got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.code       = out_code;
        got.row_last   = out_row_last;
        got.frame_last = out_frame_last;
        codes_seen++;
        if (pending_codes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected code %02h row_last %0b frame_last %0b",
                     $realtime, got.code, got.row_last, got.frame_last);
        end else begin
          want = pending_codes.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: code exp %02h got %02h, row_last exp %0b got %0b, %s %0b got %0b",
                       $realtime, want.code, got.code, want.row_last, got.row_last,
                       "frame_last exp", want.frame_last, got.frame_last);
          end
        end
        stall_left = draw_wait(stall_on);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_IMAGE_WIDTH: cfg_width = val;
      CFG_ROI_LEFT:    cfg_left  = val[10:0];
      CFG_ROI_TOP:     cfg_top   = val;
      CFG_ROI_COLUMNS: cfg_cols  = val[10:0];
      CFG_ROI_ROWS:    cfg_rows  = val;
      default: ;
    endcase
  endtask

  task automatic set_frame_cfg(input int w, input int l, input int t, input int c,
                               input int r);
    write_reg(CFG_IMAGE_WIDTH, 12'(w));
    write_reg(CFG_ROI_LEFT,    12'(l));
    write_reg(CFG_ROI_TOP,     12'(t));
    write_reg(CFG_ROI_COLUMNS, 12'(c));
    write_reg(CFG_ROI_ROWS,    12'(r));
  endtask

  task automatic push_pixels(input int count, input bit fs_first, input bit noise,
                             input int mode);
    pixel_item_t it;
    for (int i = 0; i < count; i++) begin
      it.pixel       = draw_pixel(mode);
      it.frame_start = (i == 0 && fs_first) || (noise && i > 0 && $urandom_range(0, 49) == 0);
      pixel_queue.push_back(it);
    end
  endtask

  // nothing queued, nothing in flight, no code outstanding; then let the pipe settle
  task automatic wait_drained();
    while (!(pixel_queue.size() == 0 && pixels_sent == pixels_taken &&
             pending_codes.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_frame(input int w, input int l, input int t, input int c, input int r,
                           input int count, input int mode);
    set_frame_cfg(w, l, t, c, r);
    push_pixels(count, 1'b1, 1'b0, mode);
    wait_drained();
    phases++;
  endtask

  task automatic pick_roi(input int w, input int h);
    int l, t, c, r;
    if (w >= 3 && $urandom_range(0, 3) != 0) begin
      l = $urandom_range(1, w - 2);
      c = $urandom_range(1, w - 1 - l);
      t = $urandom_range(1, h - 2);
      r = $urandom_range(1, h - 1 - t);
    end else begin
      // border, empty and oversized ROIs
      l = $urandom_range(0, w + 1);
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, w + 1);
      t = $urandom_range(0, h + 1);
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, h + 1);
    end
    write_reg(CFG_ROI_LEFT,    12'(l));
    write_reg(CFG_ROI_COLUMNS, 12'(c));
    write_reg(CFG_ROI_TOP,     12'(t));
    write_reg(CFG_ROI_ROWS,    12'(r));
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("lbp_3x3_census_stream_unit_tb: done, errors");
    $finish;
  end

  initial begin
    pix_t        directed [18];
    pixel_item_t it;
    int          random_items, w, w_eff, h, count, first_part, mode;
    bit          same_width, noise;

    // centre 100 against a mix of both extremes; then 255 against 254/255 neighbours
    directed = '{8'd0, 8'd255, 8'd7, 8'd128, 8'd100, 8'd128, 8'd255, 8'd99, 8'd101,
                 8'd254, 8'd255, 8'd254, 8'd255, 8'd255, 8'd254, 8'd255, 8'd254, 8'd255};
    clear_census_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two 3x3 frames, single centre each
    set_frame_cfg(3, 1, 1, 1, 1);
    for (int i = 0; i < 18; i++) begin
      it.pixel       = directed[i];
      it.frame_start = (i % 9 == 0);
      pixel_queue.push_back(it);
    end
    wait_drained();
    phases++;

    // width of zero acts as one: no codes, every pixel is a new row
    run_frame(0, 1, 1, 1, 1, 4, 2);

    stall_on     = 1'b1;
    send_idle_on = 1'b1;
    run_frame(1, 1, 1, 1, 1, 20, 0);
    run_frame(2, 1, 1, 1, 1, 20, 0);
    // ROI at the border and past it; column count written with a bit above the field
    run_frame(6, 0, 0, 12'h806, 6, 36, 1);
    // empty ROI, one axis at a time
    run_frame(5, 1, 1, 0, 3, 25, 0);
    run_frame(5, 1, 1, 3, 0, 25, 0);
    run_frame(10, 1, 1, 2046, 4094, 40, 3);
    run_frame(2048, 1, 1, 638, 478, 30, 0);

    // oversized width caps at the line-buffer depth
    send_idle_on = 1'b0;
    run_frame(4095, 2044, 1, 3, 1, 3 * LB_DEPTH + 2, 0);
    // row counter runs into saturation, codes keep coming from the held row
    run_frame(3, 1, 4094, 1, 1, 3 * (ROW_SAT + 12), 0);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      same_width = (cfg_width >= 3 && cfg_width <= 64 && $urandom_range(0, 4) == 0);
      if (same_width) begin
        w = cfg_width;
      end else begin
        case ($urandom_range(0, 9))
          0:       w = $urandom_range(0, 2);
          1:       w = $urandom_range(20, 64);
          default: w = $urandom_range(3, 12);
        endcase
        write_reg(CFG_IMAGE_WIDTH, 12'(w));
      end
      w_eff = (w == 0) ? 1 : w;
      h     = $urandom_range(3, 9);
      pick_roi(w, h);
      send_idle_on = ($urandom_range(0, 3) != 0);
      stall_on     = ($urandom_range(0, 3) != 0);
      mode  = $urandom_range(0, 3);
      noise = ($urandom_range(0, 3) == 0);
      count = w_eff * h + (($urandom_range(0, 2) == 0) ? $urandom_range(0, w_eff) : 0);
      if ($urandom_range(0, 3) == 0) begin
        // hold the sender mid-frame until all codes are out, maybe move the ROI
        first_part = $urandom_range(1, count - 1);
        push_pixels(first_part, !same_width, noise, mode);
        wait_drained();
        if ($urandom_range(0, 1)) pick_roi(w, h);
        push_pixels(count - first_part, 1'b0, noise, mode);
      end else begin
        push_pixels(count, !same_width, noise, mode);
      end
      wait_drained();
      random_items += count;
      phases++;
    end

    $display("ran %0d pixels in %0d phases with %0d register writes; %0d codes checked",
             pixels_taken, phases, reg_writes, codes_seen);
    $display("covered tiny, oversized and saturating geometries, border and empty ROIs; %0d %s",
             mismatch_count, "mismatches");
    if (mismatch_count == 0) begin
      $display("lbp_3x3_census_stream_unit_tb: done, clean");
    end else begin
      $display("lbp_3x3_census_stream_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
